// ===== src/cqr_pkg.sv =====
// Shared types and codes for the compacting queue with removal.
package cqr_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned ITEM_W = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ENQ      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RM_AT    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RM_MATCH = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_FAIL = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Operation broadcast to every cell
  typedef struct packed {
    logic enq;       // load the request item into the tail cell
    logic rm_at;     // cells at or after the position pull from the right
    logic rm_match;  // cells at or after the first hit pull from the right
  } cell_ctl_t;

  // Per-cell position flags from the top level
  typedef struct packed {
    logic valid;     // cell holds a live item
    logic tail;      // first free cell
    logic from_pos;  // cell index at or above the request position
  } cell_sel_t;

endpackage

// ===== src/cqr_cell.sv =====
// One storage cell of the queue: holds a slot, matches, and shifts toward the head.
module cqr_cell (
  input  logic                       clk,
  input  cqr_pkg::cell_ctl_t         ctl,
  input  cqr_pkg::cell_sel_t         sel,
  input  logic [cqr_pkg::ITEM_W-1:0] key,
  input  logic [cqr_pkg::ITEM_W-1:0] right_slot,
  input  logic                       found_in,
  output logic                       found_out,
  output logic [cqr_pkg::ITEM_W-1:0] slot
);

  logic [cqr_pkg::ITEM_W-1:0] slot_r;
  logic [cqr_pkg::ITEM_W-1:0] slot_nxt;
  logic                       hit;
  logic                       shift;

  // Match chain: a hit here or in any cell nearer the head
  assign hit       = sel.valid && (slot_r == key);
  assign found_out = found_in || hit;

  // Close the gap by taking the right neighbor's item
  assign shift = (ctl.rm_at && sel.from_pos) || (ctl.rm_match && found_out);

  always_comb begin
    slot_nxt = slot_r;
    if (shift) begin
      slot_nxt = right_slot;
    end else if (ctl.enq && sel.tail) begin
      slot_nxt = key;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot = slot_r;

endmodule

// ===== src/compacting_queue_with_removal_unit.sv =====
// Top level of the compacting queue: request decode, cell row, count and result register.
// Ordered queue of up to DEPTH item handles in a row of cells, head in cell 0. Every request
// (enqueue, dequeue, peek, remove at position, remove first matching handle) is handled by the
// whole row in parallel: the cells compare against the key and shift toward the head together,
// and the match ripples along the row as a found chain. A result appears in the cycle after its
// request and sits in an output register; a new request is taken in every cycle that register
// is empty or being drained, so the sustained rate is one request per cycle. The count and the
// result valid are the only reset state; cell contents are undefined until written.
module compacting_queue_with_removal_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] item, [35:32] position, [39:36] zero
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] item_out, [36:32] occupancy, [37] is_empty, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW    = (CNT_W > cqr_pkg::POS_W) ? CNT_W : cqr_pkg::POS_W;

  logic [cqr_pkg::ITEM_W-1:0] item;
  logic [cqr_pkg::POS_W-1:0]  position;
  logic [cqr_pkg::REQ_W-1:0]  req_type;
  logic                       accept;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [PW-1:0]    cnt_w;
  logic [PW-1:0]    pos_w;
  logic [IDX_W-1:0] rd_idx;
  logic             pos_ok;
  logic             full;
  logic             key_ok;
  logic             found;

  cqr_pkg::cell_ctl_t         ctl;
  cqr_pkg::cell_sel_t         sel   [DEPTH];
  logic [cqr_pkg::ITEM_W-1:0] slots [DEPTH];
  logic [cqr_pkg::ITEM_W-1:0] right [DEPTH];
  logic                       fchain[DEPTH+1];

  logic                        out_valid_r;
  logic [cqr_pkg::STAT_W-1:0]  status_r, status_nxt;
  logic [cqr_pkg::ITEM_W-1:0]  item_out_r, item_out_nxt;
  logic [cqr_pkg::OCC_W-1:0]   occ_r;
  logic                        empty_r;

  // Request unpacking and handshake
  assign item      = in_tdata[31:0];
  assign position  = in_tdata[35:32];
  assign req_type  = in_tuser;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Position checks; dequeue works on position zero
  assign cnt_w  = PW'(cnt_r);
  assign pos_w  = (req_type == cqr_pkg::REQ_DEQ) ? '0 : PW'(position);
  assign pos_ok = pos_w < cnt_w;
  assign rd_idx = pos_w[IDX_W-1:0];
  assign full   = cnt_r == CNT_W'(DEPTH);
  assign key_ok = item != '0;

  // Broadcast operation
  always_comb begin
    ctl.enq      = accept && (req_type == cqr_pkg::REQ_ENQ) && !full;
    ctl.rm_at    = accept && pos_ok &&
                   ((req_type == cqr_pkg::REQ_DEQ) || (req_type == cqr_pkg::REQ_RM_AT));
    ctl.rm_match = accept && key_ok && (req_type == cqr_pkg::REQ_RM_MATCH);
  end

  // Cell row
  assign fchain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign sel[i].valid    = PW'(i) < cnt_w;
    assign sel[i].tail     = PW'(i) == cnt_w;
    assign sel[i].from_pos = PW'(i) >= pos_w;
    if (i == DEPTH - 1) begin : g_last
      assign right[i] = slots[i];
    end else begin : g_mid
      assign right[i] = slots[i+1];
    end

    cqr_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .sel        (sel[i]),
      .key        (item),
      .right_slot (right[i]),
      .found_in   (fchain[i]),
      .found_out  (fchain[i+1]),
      .slot       (slots[i])
    );
  end

  assign found = fchain[DEPTH];

  // Result and count update
  always_comb begin
    status_nxt   = cqr_pkg::ST_FAIL;
    item_out_nxt = '0;
    cnt_nxt      = cnt_r;
    case (req_type)
      cqr_pkg::REQ_ENQ: begin
        if (full) begin
          status_nxt = cqr_pkg::ST_FULL;
        end else begin
          status_nxt = cqr_pkg::ST_DONE;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      cqr_pkg::REQ_DEQ: begin
        if (pos_ok) begin
          status_nxt   = cqr_pkg::ST_DONE;
          item_out_nxt = slots[rd_idx];
          cnt_nxt      = cnt_r - 1'b1;
        end
      end
      cqr_pkg::REQ_PEEK: begin
        if (pos_ok) begin
          status_nxt   = cqr_pkg::ST_DONE;
          item_out_nxt = slots[rd_idx];
        end
      end
      cqr_pkg::REQ_RM_AT: begin
        if (pos_ok) begin
          status_nxt = cqr_pkg::ST_DONE;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      cqr_pkg::REQ_RM_MATCH: begin
        if (key_ok && found) begin
          status_nxt = cqr_pkg::ST_DONE;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      default: begin
        status_nxt = cqr_pkg::ST_FAIL;
      end
    endcase
  end

  // Count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_nxt;
      item_out_r <= item_out_nxt;
      occ_r      <= cqr_pkg::OCC_W'(cnt_nxt);
      empty_r    <= cnt_nxt == '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {2'b00, empty_r, occ_r, item_out_r};

`ifndef SYNTH
  // Count never exceeds the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  // A full report means the store really is full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == cqr_pkg::ST_FULL) |-> cnt_r == CNT_W'(DEPTH))
    else $error("full status with free slots");

  // Empty flag tracks the count left by the request
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept) |-> (empty_r == (cnt_r == '0)))
    else $error("empty flag disagrees with count");

  // Count changes only on an accepted request
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cnt_r))
    else $error("count changed without a request");
`endif

endmodule
